// ----- rtl/core/gcvq_pkg.sv -----
// Package for the GC victim container queues block.
// Holds widths, command and status codes, segment metadata and controller/datapath types.
package gcvq_pkg;

   localparam int NUM_SEG     = 1024;
   localparam int SEG_W       = 10;
   localparam int MAX_CONT    = 8;
   localparam int NUM_Q       = MAX_CONT + 1;
   localparam int Q_W         = 4;
   localparam int CONT_W      = 3;
   localparam int CNT_W       = 13;
   localparam int CMD_W       = 2;
   localparam int STAT_W      = 2;
   localparam int STREAM_W    = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 13;
   localparam int WIN_W       = 17;
   localparam int SCAN_CNT_W  = 11;

   typedef enum logic [CMD_W-1:0] {
      CMD_ENQ = 2'd0,
      CMD_INV = 2'd1,
      CMD_SEL = 2'd2,
      CMD_NOP = 2'd3
   } cmd_type;

   localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
   localparam logic [STAT_W-1:0] ST_UNQUEUED = 2'd1;
   localparam logic [STAT_W-1:0] ST_NOVICTIM = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CONT_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEG_GRAINS = 2'd1;

   localparam logic [Q_W-1:0]   RESET_CONT   = 4'd4;
   localparam logic [CNT_W-1:0] RESET_GRAINS = 13'd256;

   typedef struct packed {
      logic              queued;
      logic [Q_W-1:0]    curq;
      logic [CONT_W-1:0] cont;
   } meta_type;

   localparam int META_W = $bits(meta_type);

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_CLEAR,
      OP_LATCH,
      OP_LOAD_S,
      OP_ENQ_CHK,
      OP_INV_CHK,
      OP_APPEND,
      OP_SEL_Q,
      OP_SCAN,
      OP_SEL_END,
      OP_TAKE,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    queued;
      logic    age_hit;
      logic    q_empty;
      logic    scan_last;
      logic    i_zero;
      logic    found;
      logic    clr_last;
   } dp_stat_type;

endpackage

// ----- rtl/core/gcvq_req_if.sv -----
// Request channel interface of the GC victim container queues block.
// Depends on gcvq_pkg.
interface gcvq_req_if import gcvq_pkg::*;;
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [SEG_W-1:0]    seg_index;
   logic [STREAM_W-1:0] stream_id;
   logic [CNT_W-1:0]    valid_grains;
   logic [CNT_W-1:0]    grain_count;

   modport source (output valid, cmd, seg_index, stream_id, valid_grains, grain_count,
                   input ready);
   modport sink (input valid, cmd, seg_index, stream_id, valid_grains, grain_count,
                 output ready);
endinterface

// ----- rtl/core/gcvq_rsp_if.sv -----
// Response channel interface of the GC victim container queues block.
// Depends on gcvq_pkg.
interface gcvq_rsp_if import gcvq_pkg::*;;
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [Q_W-1:0]    queue_index;
   logic [SEG_W-1:0]  victim_seg;
   logic [CNT_W-1:0]  victim_valid;

   modport source (output valid, status, queue_index, victim_seg, victim_valid,
                   input ready);
   modport sink (input valid, status, queue_index, victim_seg, victim_valid,
                 output ready);
endinterface

// ----- rtl/core/gcvq_csr_if.sv -----
// Register write channel interface of the GC victim container queues block.
// Depends on gcvq_pkg.
interface gcvq_csr_if import gcvq_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/gcvq_ram.sv -----
// Generic single write port RAM with one registered read port.
// No dependencies.
module gcvq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/gcvq_dp.sv -----
// Datapath of the GC victim container queues block: segment RAMs, queue
// head/tail registers, scan registers and result registers. Depends on gcvq_pkg, gcvq_ram.
module gcvq_dp import gcvq_pkg::*; #(
   parameter int SCAN_WINDOW = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            dp_cmd,
   output dp_stat_type           dp_stat,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [SEG_W-1:0]      req_seg_index,
   input  logic [STREAM_W-1:0]   req_stream_id,
   input  logic [CNT_W-1:0]      req_valid_grains,
   input  logic [CNT_W-1:0]      req_grain_count,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic [STAT_W-1:0]     rsp_status,
   output logic [Q_W-1:0]        rsp_queue_index,
   output logic [SEG_W-1:0]      rsp_victim_seg,
   output logic [CNT_W-1:0]      rsp_victim_valid
);

   localparam logic [WIN_W-1:0] WIN_TABLE [MAX_CONT] = '{
      WIN_W'(SCAN_WINDOW / 1), WIN_W'(SCAN_WINDOW / 2), WIN_W'(SCAN_WINDOW / 3),
      WIN_W'(SCAN_WINDOW / 4), WIN_W'(SCAN_WINDOW / 5), WIN_W'(SCAN_WINDOW / 6),
      WIN_W'(SCAN_WINDOW / 7), WIN_W'(SCAN_WINDOW / 8)};

   dp_op_type op;

   logic [Q_W-1:0]        cc_ff;
   logic [CNT_W-1:0]      sg_ff;
   logic [Q_W-1:0]        cc_wr;

   cmd_type               cmd_ff;
   logic [SEG_W-1:0]      s_ff;
   logic [STREAM_W-1:0]   stream_ff;
   logic [CNT_W-1:0]      vg_ff;
   logic [CNT_W-1:0]      gc_ff;

   logic [SEG_W-1:0]      p_ff;
   logic [SCAN_CNT_W-1:0] n_ff;
   logic [CONT_W-1:0]     i_ff;
   logic [Q_W-1:0]        q_ff;
   logic [CONT_W-1:0]     cont_ff;
   logic [SEG_W-1:0]      best_ff;
   logic [CONT_W-1:0]     bestq_ff;
   logic [CNT_W-1:0]      bestmin_ff;
   logic                  found_ff;
   logic [SEG_W-1:0]      clr_ff;

   logic [STAT_W-1:0]     res_status_ff;
   logic [Q_W-1:0]        res_q_ff;
   logic [SEG_W-1:0]      res_seg_ff;
   logic [CNT_W-1:0]      res_val_ff;
   logic [STAT_W-1:0]     out_status_ff;
   logic [Q_W-1:0]        out_q_ff;
   logic [SEG_W-1:0]      out_seg_ff;
   logic [CNT_W-1:0]      out_val_ff;

   logic [SEG_W-1:0]      head_ff  [NUM_Q];
   logic [SEG_W-1:0]      tail_ff  [NUM_Q];
   logic                  empty_ff [NUM_Q];

   logic [SEG_W-1:0]      rd_addr;
   logic                  cnt_we,  meta_we,  nxt_we,  prv_we;
   logic [SEG_W-1:0]      cnt_wa,  meta_wa,  nxt_wa,  prv_wa;
   logic [CNT_W-1:0]      cnt_wd,  cnt_rd;
   meta_type              meta_wd;
   logic [META_W-1:0]     meta_rd_raw;
   meta_type              meta_r;
   logic [SEG_W-1:0]      nxt_wd,  nxt_rd,  prv_wd,  prv_rd;

   logic [Q_W-1:0]        uq;
   logic                  u_head, u_tail, age_hit, unlink_en;
   logic [CONT_W-1:0]     cont_e;
   logic [CNT_W-1:0]      vg_sat;
   logic [Q_W-1:0]        q_e;
   logic [CNT_W-1:0]      cnt_sub;
   logic [Q_W-1:0]        i_q;
   logic [WIN_W-1:0]      win;
   logic [SCAN_CNT_W-1:0] n_inc;
   logic                  scan_last, cnt_lt;

   assign op = dp_cmd.op;

   gcvq_ram #(.WIDTH(CNT_W), .DEPTH(NUM_SEG)) u_cnt_ram (
      .clock(clock), .wr_en(cnt_we), .wr_addr(cnt_wa), .wr_data(cnt_wd),
      .rd_addr(rd_addr), .rd_data(cnt_rd));
   gcvq_ram #(.WIDTH(META_W), .DEPTH(NUM_SEG)) u_meta_ram (
      .clock(clock), .wr_en(meta_we), .wr_addr(meta_wa), .wr_data(meta_wd),
      .rd_addr(rd_addr), .rd_data(meta_rd_raw));
   gcvq_ram #(.WIDTH(SEG_W), .DEPTH(NUM_SEG)) u_next_ram (
      .clock(clock), .wr_en(nxt_we), .wr_addr(nxt_wa), .wr_data(nxt_wd),
      .rd_addr(rd_addr), .rd_data(nxt_rd));
   gcvq_ram #(.WIDTH(SEG_W), .DEPTH(NUM_SEG)) u_prev_ram (
      .clock(clock), .wr_en(prv_we), .wr_addr(prv_wa), .wr_data(prv_wd),
      .rd_addr(rd_addr), .rd_data(prv_rd));

   assign meta_r = meta_type'(meta_rd_raw);

   // unlink terms
   assign uq        = (meta_r.curq < Q_W'(NUM_Q)) ? meta_r.curq : '0;
   assign u_head    = !empty_ff[uq] && (head_ff[uq] == p_ff);
   assign u_tail    = !empty_ff[uq] && (tail_ff[uq] == p_ff);
   assign age_hit   = (meta_r.curq == cc_ff);
   assign unlink_en = (op == OP_TAKE) ||
                      ((op == OP_ENQ_CHK) && meta_r.queued) ||
                      ((op == OP_INV_CHK) && meta_r.queued && age_hit);

   // enqueue and invalidate terms
   assign cont_e  = (stream_ff < STREAM_W'(cc_ff)) ? stream_ff[CONT_W-1:0]
                                                   : CONT_W'(cc_ff - 4'd1);
   assign vg_sat  = (vg_ff > sg_ff) ? sg_ff : vg_ff;
   assign q_e     = (vg_sat == sg_ff) ? cc_ff : Q_W'(cont_e);
   assign cnt_sub = (cnt_rd > gc_ff) ? (cnt_rd - gc_ff) : '0;

   // scan terms
   assign i_q       = Q_W'(i_ff);
   assign win       = WIN_TABLE[CONT_W'(cc_ff - 4'd1)];
   assign n_inc     = n_ff + 1'b1;
   assign scan_last = ((win != '0) && (WIN_W'(n_inc) == win)) ||
                      (n_inc >= SCAN_CNT_W'(NUM_SEG)) ||
                      (p_ff == tail_ff[i_q]);
   assign cnt_lt    = (cnt_rd < bestmin_ff);

   always_comb begin
      unique case (op)
         OP_LOAD_S:  rd_addr = s_ff;
         OP_SEL_Q:   rd_addr = head_ff[i_q];
         OP_SCAN:    rd_addr = scan_last ? p_ff : nxt_rd;
         OP_SEL_END: rd_addr = best_ff;
         default:    rd_addr = p_ff;
      endcase
   end

   always_comb begin
      cnt_we  = 1'b0;
      cnt_wa  = p_ff;
      cnt_wd  = cnt_sub;
      meta_we = 1'b0;
      meta_wa = p_ff;
      meta_wd = '{queued: 1'b0, curq: meta_r.curq, cont: meta_r.cont};
      nxt_we  = 1'b0;
      nxt_wa  = prv_rd;
      nxt_wd  = nxt_rd;
      prv_we  = 1'b0;
      prv_wa  = nxt_rd;
      prv_wd  = prv_rd;
      if (unlink_en) begin
         meta_we = 1'b1;
         if (!u_head && !u_tail) begin
            nxt_we = 1'b1;
            prv_we = 1'b1;
         end
      end
      if (op == OP_CLEAR) begin
         meta_we = 1'b1;
         meta_wa = clr_ff;
         meta_wd = '0;
      end
      if (op == OP_INV_CHK) begin
         cnt_we = 1'b1;
      end
      if (op == OP_APPEND) begin
         meta_we = 1'b1;
         meta_wd = '{queued: 1'b1, curq: q_ff, cont: cont_ff};
         cnt_we  = (cmd_ff == CMD_ENQ);
         cnt_wd  = vg_sat;
         if (!empty_ff[q_ff]) begin
            nxt_we = 1'b1;
            nxt_wa = tail_ff[q_ff];
            nxt_wd = p_ff;
            prv_we = 1'b1;
            prv_wa = p_ff;
            prv_wd = tail_ff[q_ff];
         end
      end
   end

   always_comb begin
      cc_wr = csr_data[Q_W-1:0];
      if (cc_wr == '0) begin
         cc_wr = 4'd1;
      end else if (cc_wr > Q_W'(MAX_CONT)) begin
         cc_wr = Q_W'(MAX_CONT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff <= RESET_CONT;
         sg_ff <= RESET_GRAINS;
      end else if (csr_we) begin
         if (csr_index == CSR_CONT_COUNT) begin
            cc_ff <= cc_wr;
         end else if (csr_index == CSR_SEG_GRAINS) begin
            sg_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_Q; k++) begin
            head_ff[k]  <= '0;
            tail_ff[k]  <= '0;
            empty_ff[k] <= 1'b1;
         end
         clr_ff <= '0;
      end else begin
         if (unlink_en) begin
            if (u_head && u_tail) begin
               empty_ff[uq] <= 1'b1;
            end else if (u_head) begin
               head_ff[uq] <= nxt_rd;
            end else if (u_tail) begin
               tail_ff[uq] <= prv_rd;
            end
         end
         if (op == OP_APPEND) begin
            if (empty_ff[q_ff]) begin
               head_ff[q_ff]  <= p_ff;
               empty_ff[q_ff] <= 1'b0;
            end
            tail_ff[q_ff] <= p_ff;
         end
         if (op == OP_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= rd_addr;
      unique case (op)
         OP_LATCH: begin
            cmd_ff        <= cmd_type'(req_cmd);
            s_ff          <= req_seg_index;
            stream_ff     <= req_stream_id;
            vg_ff         <= req_valid_grains;
            gc_ff         <= req_grain_count;
            i_ff          <= CONT_W'(cc_ff - 4'd1);
            bestmin_ff    <= sg_ff;
            found_ff      <= 1'b0;
            res_status_ff <= ST_DONE;
            res_q_ff      <= '0;
            res_seg_ff    <= '0;
            res_val_ff    <= '0;
         end
         OP_ENQ_CHK: begin
            q_ff    <= q_e;
            cont_ff <= cont_e;
         end
         OP_INV_CHK: begin
            q_ff          <= Q_W'(meta_r.cont);
            cont_ff       <= meta_r.cont;
            res_status_ff <= meta_r.queued ? ST_DONE : ST_UNQUEUED;
            res_q_ff      <= meta_r.queued ? meta_r.curq : '0;
         end
         OP_APPEND: begin
            res_q_ff <= q_ff;
         end
         OP_SEL_Q: begin
            n_ff <= '0;
            if (empty_ff[i_q] && (i_ff != '0)) begin
               i_ff <= i_ff - 1'b1;
            end
         end
         OP_SCAN: begin
            if (cnt_lt) begin
               bestmin_ff <= cnt_rd;
               best_ff    <= p_ff;
               bestq_ff   <= i_ff;
               found_ff   <= 1'b1;
            end
            n_ff <= n_inc;
            if (scan_last && (i_ff != '0)) begin
               i_ff <= i_ff - 1'b1;
            end
         end
         OP_SEL_END: begin
            if (!found_ff) begin
               res_status_ff <= ST_NOVICTIM;
            end
         end
         OP_TAKE: begin
            res_q_ff   <= Q_W'(bestq_ff);
            res_seg_ff <= best_ff;
            res_val_ff <= bestmin_ff;
         end
         OP_OUT: begin
            out_status_ff <= res_status_ff;
            out_q_ff      <= res_q_ff;
            out_seg_ff    <= res_seg_ff;
            out_val_ff    <= res_val_ff;
         end
         default: begin
         end
      endcase
   end

   assign dp_stat.cmd       = cmd_ff;
   assign dp_stat.queued    = meta_r.queued;
   assign dp_stat.age_hit   = age_hit;
   assign dp_stat.q_empty   = empty_ff[i_q];
   assign dp_stat.scan_last = scan_last;
   assign dp_stat.i_zero    = (i_ff == '0);
   assign dp_stat.found     = found_ff;
   assign dp_stat.clr_last  = (clr_ff == '1);

   assign rsp_status       = out_status_ff;
   assign rsp_queue_index  = out_q_ff;
   assign rsp_victim_seg   = out_seg_ff;
   assign rsp_victim_valid = out_val_ff;

endmodule

// ----- rtl/core/gcvq_ctrl.sv -----
// Controller state machine of the GC victim container queues block.
// Sequences datapath operations per transaction. Depends on gcvq_pkg.
module gcvq_ctrl import gcvq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type dp_stat,
   output dp_cmd_type  dp_cmd
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_ENQ_CHK,
      S_INV_CHK,
      S_APPEND,
      S_SEL_Q,
      S_SCAN,
      S_SEL_END,
      S_TAKE,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      dp_cmd.op = OP_IDLE;
      unique case (state_ff)
         S_CLEAR: begin
            dp_cmd.op = OP_CLEAR;
            if (dp_stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.op = OP_LATCH;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            dp_cmd.op = OP_LOAD_S;
            unique case (dp_stat.cmd)
               CMD_ENQ: state_in = S_ENQ_CHK;
               CMD_INV: state_in = S_INV_CHK;
               CMD_SEL: state_in = S_SEL_Q;
               CMD_NOP: state_in = S_RESP;
            endcase
         end
         S_ENQ_CHK: begin
            dp_cmd.op = OP_ENQ_CHK;
            state_in  = S_APPEND;
         end
         S_INV_CHK: begin
            dp_cmd.op = OP_INV_CHK;
            state_in  = (dp_stat.queued && dp_stat.age_hit) ? S_APPEND : S_RESP;
         end
         S_APPEND: begin
            dp_cmd.op = OP_APPEND;
            state_in  = S_RESP;
         end
         S_SEL_Q: begin
            dp_cmd.op = OP_SEL_Q;
            priority if (!dp_stat.q_empty) state_in = S_SCAN;
            else if (dp_stat.i_zero)       state_in = S_SEL_END;
            else                           state_in = S_SEL_Q;
         end
         S_SCAN: begin
            dp_cmd.op = OP_SCAN;
            priority if (!dp_stat.scan_last) state_in = S_SCAN;
            else if (dp_stat.i_zero)         state_in = S_SEL_END;
            else                             state_in = S_SEL_Q;
         end
         S_SEL_END: begin
            dp_cmd.op = OP_SEL_END;
            state_in  = dp_stat.found ? S_TAKE : S_RESP;
         end
         S_TAKE: begin
            dp_cmd.op = OP_TAKE;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               dp_cmd.op = OP_OUT;
               state_in  = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (dp_cmd.op == OP_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/core/gc_victim_container_queues.sv -----
// GC victim container queues: per-container segment FIFOs plus an age queue.
// Select visits each non-empty container queue in turn and scans it up to the window,
// one list entry per RAM read.
// One transaction in flight; the response sits in an output register.
// Reset: synchronous; then a pass over all 1024 segments clears the queued flags, no requests taken.
module gc_victim_container_queues import gcvq_pkg::*; #(
   parameter int SCAN_WINDOW = 2048
) (
   input logic         clock,
   input logic         reset,
   gcvq_req_if.sink    req_chan,
   gcvq_rsp_if.source  rsp_chan,
   gcvq_csr_if.sink    csr_chan
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   assign csr_chan.ready = 1'b1;

   gcvq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .dp_stat   (dp_stat),
      .dp_cmd    (dp_cmd)
   );

   gcvq_dp #(.SCAN_WINDOW(SCAN_WINDOW)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .dp_cmd           (dp_cmd),
      .dp_stat          (dp_stat),
      .req_cmd          (req_chan.cmd),
      .req_seg_index    (req_chan.seg_index),
      .req_stream_id    (req_chan.stream_id),
      .req_valid_grains (req_chan.valid_grains),
      .req_grain_count  (req_chan.grain_count),
      .csr_we           (csr_chan.valid),
      .csr_index        (csr_chan.index),
      .csr_data         (csr_chan.data),
      .rsp_status       (rsp_chan.status),
      .rsp_queue_index  (rsp_chan.queue_index),
      .rsp_victim_seg   (rsp_chan.victim_seg),
      .rsp_victim_valid (rsp_chan.victim_valid)
   );

   a_clear_blocks: assert property (@(posedge clock) reset |=> !req_chan.ready)
      else $error("request taken during clearing pass");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("second transaction taken while one is in flight");

   a_novictim_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status == ST_NOVICTIM)) |->
      ((rsp_chan.victim_seg == '0) && (rsp_chan.queue_index == '0)))
      else $error("no-victim response carries a segment");

   a_out_only_in_resp: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.op == OP_OUT) |=> rsp_chan.valid)
      else $error("response load lost");

endmodule

// ----- tb/sv/tb_gc_victim_container_queues.sv -----
`timescale 1ns / 100ps
// Testbench for gc_victim_container_queues: directed and random enqueue, invalidate and
// select transactions, with predicted responses kept in a scoreboard class.
// Depends on gcvq_pkg and the three channel interfaces.
module tb_gc_victim_container_queues;
   import gcvq_pkg::*;

   typedef struct {
      cmd_type         cmd;
      logic [SEG_W-1:0]    seg;
      logic [STREAM_W-1:0] stream;
      logic [CNT_W-1:0]    vg;
      logic [CNT_W-1:0]    gc;
   } gc_req_type;

   typedef struct {
      logic [STAT_W-1:0] status;
      logic [Q_W-1:0]    qidx;
      logic [SEG_W-1:0]  vseg;
      logic [CNT_W-1:0]  vval;
   } gc_rsp_type;

   class victim_scoreboard;
      int unsigned cont_count, grains_per_seg;
      int unsigned valid_cnt[NUM_SEG];
      int unsigned home_cont[NUM_SEG];
      bit          queued[NUM_SEG];
      int unsigned cur_q[NUM_SEG];
      int unsigned nxt[NUM_SEG];
      int unsigned prv[NUM_SEG];
      int unsigned head[NUM_Q];
      int unsigned tail[NUM_Q];
      bit          empty[NUM_Q];
      gc_rsp_type  expected_rsp[$];
      int          errors;
      int          checked;
      int          victims;

      function new();
         cont_count = RESET_CONT;
         grains_per_seg = RESET_GRAINS;
         foreach (queued[i]) begin
            queued[i] = 0; valid_cnt[i] = 0; home_cont[i] = 0;
            cur_q[i] = 0; nxt[i] = 0; prv[i] = 0;
         end
         foreach (empty[i]) begin
            empty[i] = 1; head[i] = 0; tail[i] = 0;
         end
         errors = 0; checked = 0; victims = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         int unsigned c;
         if (idx == CSR_CONT_COUNT) begin
            c = data & 4'hF;
            if (c == 0) c = 1;
            if (c > MAX_CONT) c = MAX_CONT;
            cont_count = c;
         end else if (idx == CSR_SEG_GRAINS) begin
            grains_per_seg = data;
         end
      endfunction

      function void append(int unsigned s, int unsigned q);
         if (empty[q]) begin
            head[q] = s; tail[q] = s; empty[q] = 0;
         end else begin
            nxt[tail[q] % NUM_SEG] = s;
            prv[s] = tail[q];
            tail[q] = s;
         end
         cur_q[s] = q;
         queued[s] = 1;
      endfunction

      function void unlink(int unsigned s);
         int unsigned q;
         bit is_head, is_tail;
         q = cur_q[s] % NUM_Q;
         is_head = !empty[q] && head[q] == s;
         is_tail = !empty[q] && tail[q] == s;
         if (is_head && is_tail) empty[q] = 1;
         else if (is_head) head[q] = nxt[s];
         else if (is_tail) tail[q] = prv[s];
         else begin
            nxt[prv[s] % NUM_SEG] = nxt[s];
            prv[nxt[s] % NUM_SEG] = prv[s];
         end
         queued[s] = 0;
      endfunction

      function gc_rsp_type compute_response(gc_req_type r);
         gc_rsp_type o;
         int unsigned s, c, vg, q, cont, v, window, best_min, best, best_q, p, n, cur;
         bit found;
         o = '{default: '0};
         s = r.seg; c = cont_count; vg = r.vg;
         if (r.cmd == CMD_ENQ) begin
            cont = (r.stream < c) ? r.stream : c - 1;
            if (vg > grains_per_seg) vg = grains_per_seg;
            if (queued[s]) unlink(s);
            valid_cnt[s] = vg;
            home_cont[s] = cont;
            q = (vg == grains_per_seg) ? c : cont;
            append(s, q);
            o.qidx = q;
         end else if (r.cmd == CMD_INV) begin
            v = valid_cnt[s];
            valid_cnt[s] = (v > r.gc) ? v - r.gc : 0;
            if (!queued[s]) o.status = ST_UNQUEUED;
            else begin
               if (cur_q[s] == c) begin
                  unlink(s);
                  append(s, home_cont[s] % NUM_Q);
               end
               o.qidx = cur_q[s];
            end
         end else if (r.cmd == CMD_SEL) begin
            window = 2048 / c;
            best_min = grains_per_seg; best = 0; best_q = 0; found = 0;
            for (int i = c - 1; i >= 0; i--) begin
               if (empty[i]) continue;
               p = head[i] % NUM_SEG;
               n = 0;
               forever begin
                  cur = valid_cnt[p];
                  if (cur < best_min) begin
                     best_min = cur; best = p; best_q = i; found = 1;
                  end
                  n++;
                  if (window != 0 && n == window) break;
                  if (n >= NUM_SEG) break;
                  if (p == tail[i]) break;
                  p = nxt[p] % NUM_SEG;
               end
            end
            if (found) begin
               unlink(best);
               o.qidx = best_q; o.vseg = best; o.vval = valid_cnt[best];
               victims++;
            end else o.status = ST_NOVICTIM;
         end
         return o;
      endfunction

      function void note_request(gc_req_type r);
         expected_rsp.push_back(compute_response(r));
      endfunction

      function void check_response(gc_rsp_type a);
         gc_rsp_type e;
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected response status=%0d queue=%0d seg=%0d valid=%0d",
                     $time, a.status, a.qidx, a.vseg, a.vval);
            errors++;
            return;
         end
         e = expected_rsp.pop_front();
         checked++;
         if (a.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
            errors++;
         end
         if (a.qidx !== e.qidx) begin
            $display("%0t: queue_index expected %0d actual %0d", $time, e.qidx, a.qidx);
            errors++;
         end
         if (a.vseg !== e.vseg) begin
            $display("%0t: victim_seg expected %0d actual %0d", $time, e.vseg, a.vseg);
            errors++;
         end
         if (a.vval !== e.vval) begin
            $display("%0t: victim_valid expected %0d actual %0d", $time, e.vval, a.vval);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   gcvq_req_if req_if();
   gcvq_rsp_if rsp_if();
   gcvq_csr_if csr_if();

   gc_victim_container_queues i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   victim_scoreboard sb;
   bit written[NUM_SEG];
   int long_hold;
   int sent;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("tb_gc_victim_container_queues NOT OK");
      $finish;
   end

   // receiver: ready pattern switches between random modes; long hold on request
   initial begin
      int mode, left, hold;
      mode = 0; left = 0; hold = 0;
      rsp_if.ready <= 0;
      forever begin
         @(posedge clock);
         if (long_hold != 0) begin
            hold = long_hold;
            long_hold = 0;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(10, 120);
         end
         left--;
         if (hold > 0) begin
            hold--;
            rsp_if.ready <= 0;
         end else case (mode)
            0: rsp_if.ready <= 1;
            1: rsp_if.ready <= ($urandom_range(0, 1) == 1);
            2: rsp_if.ready <= ($urandom_range(0, 5) == 0);
            default: rsp_if.ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      gc_rsp_type a;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         a.status = rsp_if.status;
         a.qidx = rsp_if.queue_index;
         a.vseg = rsp_if.victim_seg;
         a.vval = rsp_if.victim_valid;
         sb.check_response(a);
      end
   end

   task automatic send_req(gc_req_type r);
      req_if.valid <= 1;
      req_if.cmd <= r.cmd;
      req_if.seg_index <= r.seg;
      req_if.stream_id <= r.stream;
      req_if.valid_grains <= r.vg;
      req_if.grain_count <= r.gc;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(r);
      if (r.cmd == CMD_ENQ) written[r.seg] = 1;
      sent++;
   endtask

   task automatic idle_sender(int n);
      req_if.valid <= 0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      idle_sender(1);
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_if.valid <= 1;
      csr_if.index <= idx;
      csr_if.data <= data;
      do @(posedge clock); while (!csr_if.ready);
      sb.write_reg(idx, data);
      csr_if.valid <= 0;
      @(posedge clock);
   endtask

   function automatic gc_req_type mk(cmd_type c, int s, int st, int vg, int g);
      gc_req_type r;
      r.cmd = c; r.seg = s; r.stream = st; r.vg = vg; r.gc = g;
      return r;
   endfunction

   function automatic int pick_written();
      int s;
      repeat (64) begin
         s = $urandom_range(0, 47);
         if (written[s]) return s;
      end
      for (int i = 0; i < NUM_SEG; i++) if (written[i]) return i;
      return -1;
   endfunction

   function automatic gc_req_type random_req();
      gc_req_type r;
      int k, s;
      k = $urandom_range(0, 99);
      r = mk(CMD_ENQ, $urandom_range(0, 47), $urandom_range(0, 9),
             $urandom_range(0, sb.grains_per_seg), $urandom_range(0, 64));
      if ($urandom_range(0, 3) == 0) r.vg = sb.grains_per_seg;
      if (k < 40) begin
         r.cmd = CMD_ENQ;
      end else if (k < 72) begin
         s = pick_written();
         if (s >= 0) begin
            r.cmd = CMD_INV; r.seg = s;
         end
      end else if (k < 94) begin
         r.cmd = CMD_SEL;
      end else begin
         r.cmd = cmd_type'($urandom_range(0, 3));
         r.seg = $urandom_range(0, NUM_SEG - 1);
         r.stream = $urandom_range(0, 255);
         r.vg = $urandom_range(0, 4096);
         r.gc = $urandom_range(0, 4096);
         if (r.cmd == CMD_INV && !written[r.seg]) r.cmd = CMD_SEL;
      end
      return r;
   endfunction

   initial begin
      int cc[6] = '{1, 8, 0, 15, 3, 9};
      int sg[6] = '{1, 4096, 256, 4095, 0, 0};
      gc_req_type dir[$];
      sb = new();
      sent = 0;
      long_hold = 0;
      reset <= 1;
      req_if.valid <= 0;
      req_if.cmd <= CMD_NOP;
      req_if.seg_index <= 0;
      req_if.stream_id <= 0;
      req_if.valid_grains <= 0;
      req_if.grain_count <= 0;
      csr_if.valid <= 0;
      csr_if.index <= CSR_CONT_COUNT;
      csr_if.data <= 0;
      repeat (8) @(posedge clock);
      reset <= 0;

      dir = '{mk(CMD_SEL, 0, 0, 0, 0),
              mk(CMD_ENQ, 0, 0, 0, 0),
              mk(CMD_ENQ, 1023, 255, 4096, 0),
              mk(CMD_ENQ, 5, 2, 256, 0),
              mk(CMD_ENQ, 682, 170, 4095, 0),
              mk(CMD_ENQ, 341, 85, 100, 0),
              mk(CMD_ENQ, 7, 1, 255, 0),
              mk(CMD_INV, 5, 0, 0, 10),
              mk(CMD_INV, 1023, 0, 0, 4096),
              mk(CMD_INV, 0, 0, 0, 0),
              mk(CMD_INV, 341, 0, 0, 4095),
              mk(CMD_ENQ, 0, 1, 100, 0),
              mk(CMD_NOP, 1023, 255, 4096, 4096),
              mk(CMD_SEL, 0, 0, 0, 0),
              mk(CMD_SEL, 0, 0, 0, 0),
              mk(CMD_SEL, 0, 0, 0, 0),
              mk(CMD_SEL, 0, 0, 0, 0),
              mk(CMD_SEL, 0, 0, 0, 0),
              mk(CMD_INV, 682, 0, 0, 1),
              mk(CMD_SEL, 0, 0, 0, 0),
              mk(CMD_SEL, 0, 0, 0, 0)};
      foreach (dir[i]) send_req(dir[i]);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_CONT_COUNT, cc[ph]);
         write_csr(CSR_SEG_GRAINS, sg[ph] != 0 ? sg[ph] : $urandom_range(1, 4096));
         for (int n = 0; n < 45; n++) begin
            if (ph == 2 && n == 5) long_hold = 500;
            if (ph == 4 && n == 20) drain();
            send_req(random_req());
            if ($urandom_range(0, 4) == 0) idle_sender($urandom_range(1, 12));
         end
         drain();
      end

      $display("covered %0d requests, %0d responses checked, %0d victims over 6 settings",
               sent, sb.checked, sb.victims);
      if (sb.errors == 0 && sb.expected_rsp.size() == 0)
         $display("tb_gc_victim_container_queues OK");
      else
         $display("tb_gc_victim_container_queues NOT OK");
      $finish;
   end
endmodule

// ----- sim.f -----
rtl/core/gcvq_pkg.sv
rtl/core/gcvq_req_if.sv
rtl/core/gcvq_rsp_if.sv
rtl/core/gcvq_csr_if.sv
rtl/core/gcvq_ram.sv
rtl/core/gcvq_dp.sv
rtl/core/gcvq_ctrl.sv
rtl/core/gc_victim_container_queues.sv
tb/sv/tb_gc_victim_container_queues.sv
